FILE: sv/atgl_pkg.sv
// ============================================================================
// atgl_pkg: shared types and constants for the address table group lookup
// Holds the request codes, the packed table entry and the packed result.
// ============================================================================
package atgl_pkg;

    // Request codes carried on the request type field.
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // A format byte at or above this value marks a group entry.
    localparam logic [7:0] GROUP_FORMAT_MIN = 8'd128;
    // Match index reported when no entry matches.
    localparam logic [7:0] NO_MATCH_INDEX = 8'hFF;

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    // One address table entry, 40 bits.
    typedef struct packed {
        logic [7:0]  format;
        logic        domain;
        logic [6:0]  member;
        logic [7:0]  group;
        logic [15:0] other;
    } t_entry;

    // One result transaction.
    typedef struct packed {
        logic       status;
        logic       found;
        logic [7:0] match_index;
        logic [6:0] member;
        t_entry     rd;
    } t_result;

    // Result with every field idle: all zero except the match index.
    function automatic t_result res_default();
        t_result r;
        r             = '0;
        r.match_index = NO_MATCH_INDEX;
        return r;
    endfunction

endpackage

FILE: sv/address_table_group_lookup_top.sv
// ============================================================================
// address_table_group_lookup_top: address table with group lookup
// Stores network address entries and serves write, read and group lookup
// requests, one result transaction per request.
// ============================================================================
//
//  Channel   Handshake                  Direction   Payload
//  request   i_in_valid / o_in_stall    in          i_req_type .. i_entry_other
//  result    o_out_valid / i_out_stall  out         o_status .. o_rd_other
//
// A write goes straight to the done state, a read through the read-data state.
// A group lookup reads the table one entry a cycle through the
// single read port and stops at the first match or after the last entry.
// Requests are handled one at a time. Reset clears every entry to zero through
// per-entry valid bits, with no clearing pass. A finished result sits in the
// output register while the next request is accepted; a stalled output holds
// the sequencer once its next result is ready.
module address_table_group_lookup_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_index,
    input  logic [7:0]  i_entry_format,
    input  logic        i_entry_domain,
    input  logic [6:0]  i_entry_member,
    input  logic [7:0]  i_entry_group,
    input  logic [15:0] i_entry_other,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic        o_found,
    output logic [7:0]  o_match_index,
    output logic [6:0]  o_member,
    output logic [7:0]  o_rd_format,
    output logic        o_rd_domain,
    output logic [6:0]  o_rd_member,
    output logic [7:0]  o_rd_group,
    output logic [15:0] o_rd_other
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    atgl_pkg::t_entry   in_entry;
    logic               we;
    logic               re;
    logic [IW-1:0]      addr;
    atgl_pkg::t_entry   wdata;
    atgl_pkg::t_entry   rdata;
    logic               res_valid;
    logic               res_take;
    atgl_pkg::t_result  res;

    atgl_pkg::t_result  r_out;
    logic               r_out_vld;

    assign in_entry.format = i_entry_format;
    assign in_entry.domain = i_entry_domain;
    assign in_entry.member = i_entry_member;
    assign in_entry.group  = i_entry_group;
    assign in_entry.other  = i_entry_other;

    atgl_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_re    (re),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    atgl_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_index     (i_index),
        .i_entry     (in_entry),
        .o_we        (we),
        .o_re        (re),
        .o_addr      (addr),
        .o_wdata     (wdata),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    // Output register: loads when empty or when its transaction leaves.
    assign res_take = res_valid && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out.status;
    assign o_found       = r_out.found;
    assign o_match_index = r_out.match_index;
    assign o_member      = r_out.member;
    assign o_rd_format   = r_out.rd.format;
    assign o_rd_domain   = r_out.rd.domain;
    assign o_rd_member   = r_out.rd.member;
    assign o_rd_group    = r_out.rd.group;
    assign o_rd_other    = r_out.rd.other;

endmodule

FILE: sv/atgl_table.sv
// ============================================================================
// atgl_table: address table storage
// Synchronous memory with one write port and one registered read port.
// A valid bit per entry makes entries that were never written read as zero.
// ============================================================================
module atgl_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IW            = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [IW-1:0]        i_addr,
    input  atgl_pkg::t_entry     i_wdata,
    output atgl_pkg::t_entry     o_rdata
);

    atgl_pkg::t_entry           r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]   r_vld;
    atgl_pkg::t_entry           r_rd_data;
    logic                       r_rd_vld;

    // Memory array: write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    // Per-entry valid bits, cleared by reset, plus the valid bit of the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_addr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_addr];
            end
        end
    end

    // An entry that was never written reads as its reset value of zero.
    assign o_rdata = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: sv/atgl_seq.sv
// ============================================================================
// atgl_seq: request sequencer and table scan
// Accepts one request at a time, drives the table ports, scans the table for
// group lookups and holds the result until the output stage takes it.
// ============================================================================
module atgl_seq #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IW            = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request side.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [7:0]           i_index,
    input  atgl_pkg::t_entry     i_entry,
    // Table side.
    output logic                 o_we,
    output logic                 o_re,
    output logic [IW-1:0]        o_addr,
    output atgl_pkg::t_entry     o_wdata,
    input  atgl_pkg::t_entry     i_rdata,
    // Result side.
    output logic                 o_res_valid,
    input  logic                 i_res_take,
    output atgl_pkg::t_result    o_res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RDATA = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [8:0]    ENTRIES_W = 9'(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_ENTRIES - 1);

    logic [1:0]           r_state, n_state;
    logic [IW-1:0]        r_addr, n_addr;
    logic                 r_issued_all, n_issued_all;
    logic [IW-1:0]        r_chk;
    logic                 r_chk_vld;
    logic                 r_key_dom, n_key_dom;
    logic [7:0]           r_key_grp, n_key_grp;
    atgl_pkg::t_result    r_res, n_res;

    logic                 accept;
    logic                 in_range;
    logic                 scan_issue;
    logic                 hit;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign in_range   = ({1'b0, i_index} < ENTRIES_W);
    assign scan_issue = (r_state == S_SCAN) && !r_issued_all;

    // Group entry whose group and domain equal the lookup key.
    assign hit = (i_rdata.format >= atgl_pkg::GROUP_FORMAT_MIN)
              && (i_rdata.group == r_key_grp)
              && (i_rdata.domain == r_key_dom);

    // Table port drive: writes and reads start straight from the request.
    always_comb begin
        o_we    = 1'b0;
        o_re    = 1'b0;
        o_addr  = r_addr;
        o_wdata = i_entry;
        if (accept) begin
            o_addr = i_index[IW-1:0];
            o_we   = (i_req_type == atgl_pkg::REQ_WRITE) && in_range;
            o_re   = (i_req_type == atgl_pkg::REQ_READ) && in_range;
        end else if (scan_issue) begin
            o_re = 1'b1;
        end
    end

    // Next state and result.
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issued_all = r_issued_all;
        n_key_dom    = r_key_dom;
        n_key_grp    = r_key_grp;
        n_res        = r_res;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res     = atgl_pkg::res_default();
                    n_key_dom = i_entry.domain;
                    n_key_grp = i_entry.group;
                    case (i_req_type)
                        atgl_pkg::REQ_WRITE: begin
                            n_res.status = in_range ? atgl_pkg::STATUS_OK
                                                    : atgl_pkg::STATUS_BAD_INDEX;
                            n_state = S_DONE;
                        end
                        atgl_pkg::REQ_READ: begin
                            if (in_range) begin
                                n_state = S_RDATA;
                            end else begin
                                n_res.status = atgl_pkg::STATUS_BAD_INDEX;
                                n_state      = S_DONE;
                            end
                        end
                        atgl_pkg::REQ_LOOKUP: begin
                            n_addr       = '0;
                            n_issued_all = 1'b0;
                            n_state      = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RDATA: begin
                n_res.rd = i_rdata;
                n_state  = S_DONE;
            end
            S_SCAN: begin
                // Issue the next address while checking the previous one.
                if (scan_issue) begin
                    n_issued_all = (r_addr == LAST_ADDR);
                    if (r_addr != LAST_ADDR) begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_chk_vld) begin
                    if (hit) begin
                        n_res.found       = 1'b1;
                        n_res.match_index = 8'(r_chk);
                        n_res.member      = i_rdata.member;
                        n_state           = S_DONE;
                    end else if (r_chk == LAST_ADDR) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issued_all <= 1'b0;
            r_chk_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issued_all <= n_issued_all;
            r_chk_vld    <= scan_issue;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_chk     <= r_addr;
        r_key_dom <= n_key_dom;
        r_key_grp <= n_key_grp;
        r_res     <= n_res;
    end

    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule
